@@ hdl/scee_pkg.sv @@
package scee_pkg;

  localparam int MAX_SPHERES  = 16;
  localparam int MAX_MISSILES = 16;
  localparam int FRAC_BITS    = 16;

  localparam int SPH_AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int MIS_AW = (MAX_MISSILES > 1) ? $clog2(MAX_MISSILES) : 1;

  localparam int REQ_W  = 3;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;
  localparam int CFG_IW = 1;

  // usable table spans; the index field reaches only 16 spheres
  localparam int SPAN    = (MAX_SPHERES < 16) ? MAX_SPHERES : 16;
  localparam int MIS_LIM = (MAX_MISSILES < 31) ? MAX_MISSILES : 31;

  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int QB     = FRAC_BITS + 3;
  localparam int CW     = QB + 1;
  localparam int NMW    = FRAC_BITS + 34;
  localparam int NW     = FRAC_BITS + 36;
  localparam int QCW    = $clog2(QB);

  localparam logic [REQ_W-1:0] REQ_LOAD_SPH = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_MIS = 3'd1;
  localparam logic [REQ_W-1:0] REQ_COLLIDE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_STRIKE   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ_SPH = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ_MIS = 3'd5;

  localparam logic [CFG_IW-1:0] CFG_OBJECT_COUNT  = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_MISSILE_COUNT = 1'b1;

  localparam logic [1:0] SEL_C1 = 2'd0;
  localparam logic [1:0] SEL_C2 = 2'd1;
  localparam logic [1:0] SEL_C3 = 2'd2;
  localparam logic [1:0] AX_LAST = 2'd2;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD_IN, OP_WR_SPH, OP_WR_MIS, OP_CAP_A, OP_CAP_B, OP_CAP_M,
    OP_DIFF, OP_SQ_DX, OP_SQ_DY, OP_SQ_DZ, OP_SQ_R, OP_CMP, OP_SWAP,
    OP_DIV_START, OP_CAP_C, OP_AX_LD, OP_M_C1A, OP_M_C2B, OP_M_NC1B,
    OP_M_C3A, OP_FIN2, OP_FIN3, OP_WR_VA, OP_WR_VB, OP_FLAG_CLR,
    OP_OUT_VEL, OP_OUT_FLAG, OP_OUT_SURV
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SPH_AW-1:0] saddr;
    logic [MIS_AW-1:0] maddr;
    logic [1:0]        sel;
    logic [IDX_W-1:0]  oidx;
    logic              olast;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [IDX_W-1:0] idx;
    logic             ov;
    logic             meq;
    logic             div_busy;
    logic             out_free;
    logic             mflag;
  } stat_t;

endpackage

@@ hdl/scee_ram.sv @@
module scee_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                        wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                        rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/scee_dp.sv @@
module scee_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [scee_pkg::REQ_W-1:0]    in_req_type,
  input  logic [scee_pkg::IDX_W-1:0]    in_index,
  input  logic signed [31:0]            in_pos_x,
  input  logic signed [31:0]            in_pos_y,
  input  logic signed [31:0]            in_pos_z,
  input  logic signed [31:0]            in_vel_x,
  input  logic signed [31:0]            in_vel_y,
  input  logic signed [31:0]            in_vel_z,
  input  logic [31:0]                   in_radius,
  input  logic [31:0]                   in_mass,
  input  logic                          in_active,
  input  scee_pkg::cmd_t                cmd,
  output scee_pkg::stat_t               stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [scee_pkg::IDX_W-1:0]    out_object_index,
  output logic                          out_survivor_valid,
  output logic signed [31:0]            out_vel_x,
  output logic signed [31:0]            out_vel_y,
  output logic signed [31:0]            out_vel_z,
  output logic                          out_missile_active,
  output logic                          out_last
);
  import scee_pkg::*;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // round to nearest, ties away from zero, then clamp to 32 bits
  function automatic logic signed [31:0] sat_round(input logic signed [ACC_W-1:0] s);
    logic [ACC_W-1:0] m;
    logic [ACC_W-1:0] q;
    m = s[ACC_W-1] ? ACC_W'(-s) : ACC_W'(s);
    q = (m + (ACC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (!s[ACC_W-1]) begin
      return (q > ACC_W'(32'h7fff_ffff)) ? 32'sh7fff_ffff : $signed(q[31:0]);
    end
    return (q > ACC_W'(33'h0_8000_0000)) ? 32'sh8000_0000 : $signed(-q[31:0]);
  endfunction

  // latched request
  logic [REQ_W-1:0]   req_r;
  logic [IDX_W-1:0]   idx_r;
  logic signed [31:0] ipos_r [3];
  logic signed [31:0] ivel_r [3];
  logic [31:0]        irad_r, imass_r;
  logic               iact_r;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD_IN) begin
      req_r     <= in_req_type;
      idx_r     <= in_index;
      ipos_r[0] <= in_pos_x;
      ipos_r[1] <= in_pos_y;
      ipos_r[2] <= in_pos_z;
      ivel_r[0] <= in_vel_x;
      ivel_r[1] <= in_vel_y;
      ivel_r[2] <= in_vel_z;
      irad_r    <= in_radius;
      imass_r   <= in_mass;
      iact_r    <= in_active;
    end
  end

  logic sph_in, mis_in;
  assign sph_in = int'(idx_r) < MAX_SPHERES;
  assign mis_in = int'(idx_r) < MAX_MISSILES;

  // tables
  logic               s_we, v_we, m_we;
  logic [SPH_AW-1:0]  v_waddr;
  logic [159:0]       s_rdata;
  logic [95:0]        v_wdata, v_rdata;
  logic [127:0]       m_rdata;
  logic signed [31:0] va [3];
  logic signed [31:0] vb [3];

  assign s_we    = (cmd.op == OP_WR_SPH) && sph_in;
  assign m_we    = (cmd.op == OP_WR_MIS) && mis_in;
  assign v_we    = s_we || (cmd.op == OP_WR_VA) || (cmd.op == OP_WR_VB);
  assign v_waddr = (cmd.op == OP_WR_SPH) ? SPH_AW'(idx_r) : cmd.saddr;

  always_comb begin
    priority if (cmd.op == OP_WR_SPH) begin
      v_wdata = {ivel_r[2], ivel_r[1], ivel_r[0]};
    end else if (cmd.op == OP_WR_VA) begin
      v_wdata = {va[2], va[1], va[0]};
    end else begin
      v_wdata = {vb[2], vb[1], vb[0]};
    end
  end

  scee_ram #(.W(160), .D(MAX_SPHERES)) u_sph_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (SPH_AW'(idx_r)),
    .wdata ({imass_r, irad_r, ipos_r[2], ipos_r[1], ipos_r[0]}),
    .raddr (cmd.saddr),
    .rdata (s_rdata)
  );

  scee_ram #(.W(96), .D(MAX_SPHERES)) u_vel_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (cmd.saddr),
    .rdata (v_rdata)
  );

  scee_ram #(.W(128), .D(MAX_MISSILES)) u_mis_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (MIS_AW'(idx_r)),
    .wdata ({irad_r, ipos_r[2], ipos_r[1], ipos_r[0]}),
    .raddr (cmd.maddr),
    .rdata (m_rdata)
  );

  logic [MAX_MISSILES-1:0] mflag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mflag_r <= '0;
    end else if (m_we) begin
      mflag_r[MIS_AW'(idx_r)] <= iact_r;
    end else if (cmd.op == OP_FLAG_CLR) begin
      mflag_r[cmd.maddr] <= 1'b0;
    end
  end

  // operand registers
  logic signed [31:0]   apos [3];
  logic signed [31:0]   bpos [3];
  logic [31:0]          arad, brad, amass, bmass;
  logic [32:0]          dmag [3];
  logic [32:0]          rs_r;
  logic signed [31:0]   a_r, b_r;
  logic signed [CW-1:0] c1_r, c2_r, c3_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                 ov_r;
  logic signed [MUL_W-1:0]  ma, mb;
  logic signed [CW-1:0] qs;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_SQ_DX:  begin ma = $signed({1'b0, dmag[0]}); mb = ma; end
      OP_SQ_DY:  begin ma = $signed({1'b0, dmag[1]}); mb = ma; end
      OP_SQ_DZ:  begin ma = $signed({1'b0, dmag[2]}); mb = ma; end
      OP_SQ_R:   begin ma = $signed({1'b0, rs_r});    mb = ma; end
      OP_M_C1A:  begin ma = MUL_W'(c1_r);  mb = MUL_W'(a_r); end
      OP_M_C2B:  begin ma = MUL_W'(c2_r);  mb = MUL_W'(b_r); end
      OP_M_NC1B: begin ma = -MUL_W'(c1_r); mb = MUL_W'(b_r); end
      OP_M_C3A:  begin ma = MUL_W'(c3_r);  mb = MUL_W'(a_r); end
      default:   begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAP_A: begin
        apos[0] <= s_rdata[31:0];
        apos[1] <= s_rdata[63:32];
        apos[2] <= s_rdata[95:64];
        arad    <= s_rdata[127:96];
        amass   <= s_rdata[159:128];
        va[0]   <= v_rdata[31:0];
        va[1]   <= v_rdata[63:32];
        va[2]   <= v_rdata[95:64];
      end
      OP_CAP_B: begin
        bpos[0] <= s_rdata[31:0];
        bpos[1] <= s_rdata[63:32];
        bpos[2] <= s_rdata[95:64];
        brad    <= s_rdata[127:96];
        bmass   <= s_rdata[159:128];
        vb[0]   <= v_rdata[31:0];
        vb[1]   <= v_rdata[63:32];
        vb[2]   <= v_rdata[95:64];
      end
      OP_CAP_M: begin
        bpos[0] <= m_rdata[31:0];
        bpos[1] <= m_rdata[63:32];
        bpos[2] <= m_rdata[95:64];
        brad    <= m_rdata[127:96];
      end
      OP_DIFF: begin
        for (int ax = 0; ax < 3; ax++) begin
          dmag[ax] <= mag33(33'(apos[ax]) - 33'(bpos[ax]));
        end
        rs_r <= {1'b0, arad} + {1'b0, brad};
      end
      OP_SQ_DX: prod_r <= ma * mb;
      OP_SQ_DY: begin prod_r <= ma * mb; acc_r <= ACC_W'(prod_r); end
      OP_SQ_DZ: begin prod_r <= ma * mb; acc_r <= acc_r + ACC_W'(prod_r); end
      OP_SQ_R:  begin prod_r <= ma * mb; acc_r <= acc_r + ACC_W'(prod_r); end
      OP_CMP:   ov_r <= acc_r <= ACC_W'(prod_r);
      OP_SWAP: begin
        va <= vb;
        vb <= va;
      end
      OP_CAP_C: begin
        if (cmd.sel == SEL_C1) c1_r <= qs;
        else if (cmd.sel == SEL_C2) c2_r <= qs;
        else c3_r <= qs;
      end
      OP_AX_LD: begin
        a_r <= va[cmd.sel];
        b_r <= vb[cmd.sel];
      end
      OP_M_C1A:  prod_r <= ma * mb;
      OP_M_C2B:  begin prod_r <= ma * mb; acc_r <= ACC_W'(prod_r); end
      OP_M_NC1B: begin prod_r <= ma * mb; acc_r <= acc_r + ACC_W'(prod_r); end
      OP_M_C3A: begin
        prod_r      <= ma * mb;
        va[cmd.sel] <= sat_round(acc_r);
        acc_r       <= ACC_W'(prod_r);
      end
      OP_FIN2: acc_r <= acc_r + ACC_W'(prod_r);
      OP_FIN3: vb[cmd.sel] <= sat_round(acc_r);
      default: ;
    endcase
  end

  // restoring divider, one quotient bit per cycle
  logic signed [32:0] mdiff;
  logic [32:0]        msum;
  logic [NMW-1:0]     nmag;
  logic [NW-1:0]      rem_r, dsh_r;
  logic [QB-1:0]      q_r;
  logic [QCW-1:0]     dcnt_r;
  logic               busy_r, neg_r;
  logic               ge;

  assign mdiff = $signed({1'b0, amass}) - $signed({1'b0, bmass});
  assign msum  = {1'b0, amass} + {1'b0, bmass};
  assign ge    = rem_r >= dsh_r;
  assign qs    = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  always_comb begin
    unique case (cmd.sel)
      SEL_C1:  nmag = NMW'(mag33(mdiff)) << FRAC_BITS;
      SEL_C2:  nmag = NMW'({bmass, 1'b0}) << FRAC_BITS;
      default: nmag = NMW'({amass, 1'b0}) << FRAC_BITS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd.op == OP_DIV_START) begin
      busy_r <= 1'b1;
    end else if (busy_r && dcnt_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIV_START) begin
      rem_r  <= NW'({nmag, 1'b0}) + NW'(msum);
      dsh_r  <= NW'({msum, 1'b0}) << (QB - 1);
      q_r    <= '0;
      dcnt_r <= QCW'(QB - 1);
      neg_r  <= (cmd.sel == SEL_C1) && mdiff[32];
    end else if (busy_r) begin
      rem_r  <= ge ? rem_r - dsh_r : rem_r;
      q_r    <= {q_r[QB-2:0], ge};
      dsh_r  <= dsh_r >> 1;
      dcnt_r <= dcnt_r - QCW'(1);
    end
  end

  // output register
  logic out_free, push;
  assign out_free = !out_valid || out_ready;
  assign push = (cmd.op == OP_OUT_VEL) || (cmd.op == OP_OUT_FLAG) || (cmd.op == OP_OUT_SURV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_survivor_valid <= 1'b0;
      out_vel_x          <= '0;
      out_vel_y          <= '0;
      out_vel_z          <= '0;
      out_missile_active <= 1'b0;
      out_last           <= 1'b1;
      out_object_index   <= idx_r;
      unique case (cmd.op)
        OP_OUT_VEL: begin
          if (sph_in) begin
            out_vel_x <= v_rdata[31:0];
            out_vel_y <= v_rdata[63:32];
            out_vel_z <= v_rdata[95:64];
          end
        end
        OP_OUT_FLAG: out_missile_active <= mis_in && mflag_r[MIS_AW'(idx_r)];
        default: begin
          out_object_index   <= cmd.oidx;
          out_survivor_valid <= 1'b1;
          out_last           <= cmd.olast;
        end
      endcase
    end
  end

  assign stat.req      = req_r;
  assign stat.idx      = idx_r;
  assign stat.ov       = ov_r;
  assign stat.meq      = amass == bmass;
  assign stat.div_busy = busy_r;
  assign stat.out_free = out_free;
  assign stat.mflag    = mflag_r[cmd.maddr];

endmodule

@@ hdl/scee_ctrl.sv @@
module scee_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [scee_pkg::CFG_IW-1:0] cfg_index,
  input  logic [scee_pkg::CNT_W-1:0]  cfg_data,
  input  scee_pkg::stat_t             stat,
  output scee_pkg::cmd_t              cmd
);
  import scee_pkg::*;

  localparam int STW = 33;

  typedef enum logic [STW-1:0] {
    ST_IDLE   = STW'(1) << 0,  ST_DISP   = STW'(1) << 1,  ST_RD_A   = STW'(1) << 2,
    ST_CAP_A  = STW'(1) << 3,  ST_CAP_B  = STW'(1) << 4,  ST_CAP_M  = STW'(1) << 5,
    ST_DIFF   = STW'(1) << 6,  ST_SQX    = STW'(1) << 7,  ST_SQY    = STW'(1) << 8,
    ST_SQZ    = STW'(1) << 9,  ST_SQR    = STW'(1) << 10, ST_CMP    = STW'(1) << 11,
    ST_C_DEC  = STW'(1) << 12, ST_C_DIVS = STW'(1) << 13, ST_C_DIVW = STW'(1) << 14,
    ST_C_AXL  = STW'(1) << 15, ST_C_M1   = STW'(1) << 16, ST_C_M2   = STW'(1) << 17,
    ST_C_M3   = STW'(1) << 18, ST_C_M4   = STW'(1) << 19, ST_C_M5   = STW'(1) << 20,
    ST_C_M6   = STW'(1) << 21, ST_C_WRA  = STW'(1) << 22, ST_C_WRB  = STW'(1) << 23,
    ST_C_NEXT = STW'(1) << 24, ST_S_K    = STW'(1) << 25, ST_S_MDEC = STW'(1) << 26,
    ST_S_SURV = STW'(1) << 27, ST_S_NEXT = STW'(1) << 28, ST_S_FLUSH = STW'(1) << 29,
    ST_R_SPH  = STW'(1) << 30, ST_R_SPH2 = STW'(1) << 31, ST_R_MIS  = STW'(1) << 32
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] obj_cnt_r, mis_cnt_r;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [1:0]       csel_r, csel_nxt, ax_r, ax_nxt;
  logic             strike_r, strike_nxt, pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [CNT_W-1:0] ns, nm;

  assign cfg_ready = 1'b1;
  assign ns = (obj_cnt_r > CNT_W'(SPAN)) ? CNT_W'(SPAN) : obj_cnt_r;
  assign nm = (mis_cnt_r > CNT_W'(MIS_LIM)) ? CNT_W'(MIS_LIM) : mis_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obj_cnt_r <= '0;
      mis_cnt_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_OBJECT_COUNT) obj_cnt_r <= cfg_data;
      else if (cfg_index == CFG_MISSILE_COUNT) mis_cnt_r <= cfg_data;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    csel_nxt     = csel_r;
    ax_nxt       = ax_r;
    strike_nxt   = strike_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    in_ready     = 1'b0;
    cmd.op       = OP_NOP;
    cmd.saddr    = SPH_AW'(j_r);
    cmd.maddr    = MIS_AW'(k_r);
    cmd.sel      = ax_r;
    cmd.oidx     = pend_idx_r;
    cmd.olast    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD_IN;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        state_nxt = ST_IDLE;
        unique case (stat.req)
          REQ_LOAD_SPH: cmd.op = OP_WR_SPH;
          REQ_LOAD_MIS: cmd.op = OP_WR_MIS;
          REQ_COLLIDE: begin
            strike_nxt = 1'b0;
            i_nxt      = '0;
            j_nxt      = CNT_W'(1);
            if (ns >= CNT_W'(2)) state_nxt = ST_RD_A;
          end
          REQ_STRIKE: begin
            strike_nxt = 1'b1;
            j_nxt      = '0;
            k_nxt      = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = (ns == '0) ? ST_S_FLUSH : ST_RD_A;
          end
          REQ_READ_SPH: state_nxt = ST_R_SPH;
          REQ_READ_MIS: state_nxt = ST_R_MIS;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_RD_A: begin
        cmd.saddr = strike_r ? SPH_AW'(j_r) : SPH_AW'(i_r);
        state_nxt = ST_CAP_A;
      end
      ST_CAP_A: begin
        cmd.op    = OP_CAP_A;
        state_nxt = strike_r ? ST_S_K : ST_CAP_B;
      end
      ST_CAP_B: begin cmd.op = OP_CAP_B; state_nxt = ST_DIFF; end
      ST_CAP_M: begin cmd.op = OP_CAP_M; state_nxt = ST_DIFF; end
      ST_DIFF:  begin cmd.op = OP_DIFF;  state_nxt = ST_SQX; end
      ST_SQX:   begin cmd.op = OP_SQ_DX; state_nxt = ST_SQY; end
      ST_SQY:   begin cmd.op = OP_SQ_DY; state_nxt = ST_SQZ; end
      ST_SQZ:   begin cmd.op = OP_SQ_DZ; state_nxt = ST_SQR; end
      ST_SQR:   begin cmd.op = OP_SQ_R;  state_nxt = ST_CMP; end
      ST_CMP: begin
        cmd.op    = OP_CMP;
        state_nxt = strike_r ? ST_S_MDEC : ST_C_DEC;
      end
      ST_C_DEC: begin
        priority if (!stat.ov) begin
          state_nxt = ST_C_NEXT;
        end else if (stat.meq) begin
          cmd.op    = OP_SWAP;
          state_nxt = ST_C_WRA;
        end else begin
          csel_nxt  = SEL_C1;
          state_nxt = ST_C_DIVS;
        end
      end
      ST_C_DIVS: begin
        cmd.op    = OP_DIV_START;
        cmd.sel   = csel_r;
        state_nxt = ST_C_DIVW;
      end
      ST_C_DIVW: begin
        cmd.sel = csel_r;
        if (!stat.div_busy) begin
          cmd.op = OP_CAP_C;
          if (csel_r == SEL_C3) begin
            ax_nxt    = '0;
            state_nxt = ST_C_AXL;
          end else begin
            csel_nxt  = csel_r + 2'd1;
            state_nxt = ST_C_DIVS;
          end
        end
      end
      ST_C_AXL: begin cmd.op = OP_AX_LD;  state_nxt = ST_C_M1; end
      ST_C_M1:  begin cmd.op = OP_M_C1A;  state_nxt = ST_C_M2; end
      ST_C_M2:  begin cmd.op = OP_M_C2B;  state_nxt = ST_C_M3; end
      ST_C_M3:  begin cmd.op = OP_M_NC1B; state_nxt = ST_C_M4; end
      ST_C_M4:  begin cmd.op = OP_M_C3A;  state_nxt = ST_C_M5; end
      ST_C_M5:  begin cmd.op = OP_FIN2;   state_nxt = ST_C_M6; end
      ST_C_M6: begin
        cmd.op = OP_FIN3;
        if (ax_r == AX_LAST) begin
          state_nxt = ST_C_WRA;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = ST_C_AXL;
        end
      end
      ST_C_WRA: begin
        cmd.op    = OP_WR_VA;
        cmd.saddr = SPH_AW'(i_r);
        state_nxt = ST_C_WRB;
      end
      ST_C_WRB: begin cmd.op = OP_WR_VB; state_nxt = ST_C_NEXT; end
      ST_C_NEXT: begin
        priority if (j_r + CNT_W'(1) < ns) begin
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = ST_RD_A;
        end else if (i_r + CNT_W'(2) < ns) begin
          i_nxt     = i_r + CNT_W'(1);
          j_nxt     = i_r + CNT_W'(2);
          state_nxt = ST_RD_A;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_S_K: begin
        priority if (k_r >= nm) begin
          state_nxt = ST_S_SURV;
        end else if (!stat.mflag) begin
          k_nxt = k_r + CNT_W'(1);
        end else begin
          state_nxt = ST_CAP_M;
        end
      end
      ST_S_MDEC: begin
        if (stat.ov) begin
          cmd.op    = OP_FLAG_CLR;
          state_nxt = ST_S_NEXT;
        end else begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = ST_S_K;
        end
      end
      ST_S_SURV: begin
        // a survivor is held back one step so the final one can carry last
        if (!pend_v_r || stat.out_free) begin
          if (pend_v_r) cmd.op = OP_OUT_SURV;
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = IDX_W'(j_r);
          state_nxt    = ST_S_NEXT;
        end
      end
      ST_S_NEXT: begin
        if (j_r + CNT_W'(1) < ns) begin
          j_nxt     = j_r + CNT_W'(1);
          k_nxt     = '0;
          state_nxt = ST_RD_A;
        end else begin
          state_nxt = ST_S_FLUSH;
        end
      end
      ST_S_FLUSH: begin
        cmd.olast = 1'b1;
        priority if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.op     = OP_OUT_SURV;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_S_FLUSH;
        end
      end
      ST_R_SPH: begin
        cmd.saddr = SPH_AW'(stat.idx);
        state_nxt = ST_R_SPH2;
      end
      ST_R_SPH2: begin
        cmd.saddr = SPH_AW'(stat.idx);
        if (stat.out_free) begin
          cmd.op    = OP_OUT_VEL;
          state_nxt = ST_IDLE;
        end
      end
      ST_R_MIS: begin
        if (stat.out_free) begin
          cmd.op    = OP_OUT_FLAG;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strike_r <= 1'b0;
      pend_v_r <= 1'b0;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
      csel_r   <= '0;
      ax_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      strike_r <= strike_nxt;
      pend_v_r <= pend_v_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      k_r      <= k_nxt;
      csel_r   <= csel_nxt;
      ax_r     <= ax_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT_VEL || cmd.op == OP_OUT_FLAG || cmd.op == OP_OUT_SURV)
      |-> stat.out_free)
    else $error("result pushed into a full output register");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_DIV_START) |-> !stat.div_busy)
    else $error("divider restarted while busy");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD_A && !strike_r) |-> (i_r < j_r && j_r < ns))
    else $error("collide pair out of order or beyond span");

endmodule

@@ hdl/sphere_collision_elastic_engine.sv @@
// Reads stall while the output register is full; results wait
// in an output register while the next beat is taken.
// Collide pass: pairs without contact are skipped, equal-mass contact swaps velocities,
// else three 19-step divisions, then C_AXL and C_M1 to C_M6 per axis on one multiplier.
// Strike: each sphere is tested against the active missiles in turn; idle ones are skipped.
// Reset (synchronous, rst_n low) clears counts, missile flags and control; tables stay.
module sphere_collision_elastic_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [scee_pkg::REQ_W-1:0]  in_req_type,
  input  logic [scee_pkg::IDX_W-1:0]  in_index,
  input  logic signed [31:0]          in_pos_x,
  input  logic signed [31:0]          in_pos_y,
  input  logic signed [31:0]          in_pos_z,
  input  logic signed [31:0]          in_vel_x,
  input  logic signed [31:0]          in_vel_y,
  input  logic signed [31:0]          in_vel_z,
  input  logic [31:0]                 in_radius,
  input  logic [31:0]                 in_mass,
  input  logic                        in_active,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [scee_pkg::IDX_W-1:0]  out_object_index,
  output logic                        out_survivor_valid,
  output logic signed [31:0]          out_vel_x,
  output logic signed [31:0]          out_vel_y,
  output logic signed [31:0]          out_vel_z,
  output logic                        out_missile_active,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [scee_pkg::CFG_IW-1:0] cfg_index,
  input  logic [scee_pkg::CNT_W-1:0]  cfg_data
);
  import scee_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  scee_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .cmd       (cmd)
  );

  scee_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_req_type        (in_req_type),
    .in_index           (in_index),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_vel_x           (in_vel_x),
    .in_vel_y           (in_vel_y),
    .in_vel_z           (in_vel_z),
    .in_radius          (in_radius),
    .in_mass            (in_mass),
    .in_active          (in_active),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_object_index   (out_object_index),
    .out_survivor_valid (out_survivor_valid),
    .out_vel_x          (out_vel_x),
    .out_vel_y          (out_vel_y),
    .out_vel_z          (out_vel_z),
    .out_missile_active (out_missile_active),
    .out_last           (out_last)
  );

endmodule

@@ tb/tb_sphere_collision_elastic_engine.sv @@
`timescale 1ns / 1ps

module tb_sphere_collision_elastic_engine;
  import scee_pkg::*;

  // request codes that the block ignores
  localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd7;

  typedef struct {
    logic [REQ_W-1:0] req;
    logic [IDX_W-1:0] idx;
    logic [31:0]      px, py, pz, vx, vy, vz;
    logic [31:0]      radius, mass;
    logic             active;
  } request_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic             surv;
    logic [31:0]      vx, vy, vz;
    logic             flag;
    logic             last;
  } result_t;

  class collision_scoreboard;
    longint          s_px[16], s_py[16], s_pz[16], s_vx[16], s_vy[16], s_vz[16];
    longint unsigned s_rad[16], s_mass[16];
    longint          m_px[16], m_py[16], m_pz[16];
    longint unsigned m_rad[16];
    bit              m_flag[16];
    int unsigned     obj_cnt, mis_cnt;
    result_t         pending_results[$];
    int              errors;

    function new();
      foreach (m_flag[k]) m_flag[k] = 0;
      obj_cnt = 0;
      mis_cnt = 0;
      errors  = 0;
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function bit overlap(longint ax, longint ay, longint az, longint bx, longint by,
                         longint bz, longint unsigned ra, longint unsigned rb);
      logic [71:0] d2, r2;
      longint unsigned m;
      m  = mag(ax - bx);
      d2 = 72'(m) * 72'(m);
      m  = mag(ay - by);
      d2 = d2 + 72'(m) * 72'(m);
      m  = mag(az - bz);
      d2 = d2 + 72'(m) * 72'(m);
      r2 = 72'(ra + rb) * 72'(ra + rb);
      return d2 <= r2;
    endfunction

    function longint div_round(longint n, longint unsigned d);
      longint unsigned q;
      q = (2 * mag(n) + d) / (2 * d);
      return n < 0 ? -longint'(q) : longint'(q);
    endfunction

    function longint scale_sat(longint s);
      longint unsigned q;
      longint r;
      q = (mag(s) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      r = s < 0 ? -longint'(q) : longint'(q);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r;
    endfunction

    function void bounce(ref longint v1, ref longint v2, input longint unsigned m1,
                         input longint unsigned m2);
      longint unsigned sum;
      longint c1, c2, c3, a, b;
      sum = m1 + m2;
      c1  = div_round((longint'(m1) - longint'(m2)) * (64'sd1 <<< FRAC_BITS), sum);
      c2  = div_round(longint'((2 * m2) << FRAC_BITS), sum);
      c3  = div_round(longint'((2 * m1) << FRAC_BITS), sum);
      a   = v1;
      b   = v2;
      v1  = scale_sat(c1 * a + c2 * b);
      v2  = scale_sat(-c1 * b + c3 * a);
    endfunction

    function void set_count(logic [CFG_IW-1:0] which, logic [CNT_W-1:0] val);
      if (which == CFG_OBJECT_COUNT) obj_cnt = val;
      else mis_cnt = val;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void add_result(int idx, bit surv, longint vx, longint vy, longint vz,
                             bit flag, bit last);
      result_t r;
      r.idx  = IDX_W'(idx);
      r.surv = surv;
      r.vx   = vx[31:0];
      r.vy   = vy[31:0];
      r.vz   = vz[31:0];
      r.flag = flag;
      r.last = last;
      pending_results = {pending_results, r};
    endfunction

    function void note_request(request_t it);
      int ns, nm, first;
      bit hit;
      longint t;
      ns = obj_cnt > 16 ? 16 : obj_cnt;
      nm = mis_cnt > 16 ? 16 : mis_cnt;
      case (it.req)
        REQ_LOAD_SPH: begin
          s_px[it.idx]   = longint'(signed'(it.px));
          s_py[it.idx]   = longint'(signed'(it.py));
          s_pz[it.idx]   = longint'(signed'(it.pz));
          s_vx[it.idx]   = longint'(signed'(it.vx));
          s_vy[it.idx]   = longint'(signed'(it.vy));
          s_vz[it.idx]   = longint'(signed'(it.vz));
          s_rad[it.idx]  = it.radius;
          s_mass[it.idx] = it.mass;
        end
        REQ_LOAD_MIS: begin
          m_px[it.idx]   = longint'(signed'(it.px));
          m_py[it.idx]   = longint'(signed'(it.py));
          m_pz[it.idx]   = longint'(signed'(it.pz));
          m_rad[it.idx]  = it.radius;
          m_flag[it.idx] = it.active;
        end
        REQ_COLLIDE: begin
          for (int i = 0; i < ns; i++)
            for (int j = i + 1; j < ns; j++) begin
              if (!overlap(s_px[i], s_py[i], s_pz[i], s_px[j], s_py[j], s_pz[j],
                           s_rad[i], s_rad[j])) continue;
              if (s_mass[i] == s_mass[j]) begin
                t = s_vx[i]; s_vx[i] = s_vx[j]; s_vx[j] = t;
                t = s_vy[i]; s_vy[i] = s_vy[j]; s_vy[j] = t;
                t = s_vz[i]; s_vz[i] = s_vz[j]; s_vz[j] = t;
              end else begin
                bounce(s_vx[i], s_vx[j], s_mass[i], s_mass[j]);
                bounce(s_vy[i], s_vy[j], s_mass[i], s_mass[j]);
                bounce(s_vz[i], s_vz[j], s_mass[i], s_mass[j]);
              end
            end
        end
        REQ_STRIKE: begin
          first = pending_results.size();
          for (int j = 0; j < ns; j++) begin
            hit = 0;
            for (int k = 0; k < nm && !hit; k++)
              if (m_flag[k] && overlap(m_px[k], m_py[k], m_pz[k], s_px[j], s_py[j],
                                       s_pz[j], m_rad[k], s_rad[j])) begin
                m_flag[k] = 0;
                hit = 1;
              end
            if (!hit) add_result(j, 1, 0, 0, 0, 0, 0);
          end
          if (pending_results.size() > first)
            pending_results[pending_results.size() - 1].last = 1;
        end
        REQ_READ_SPH: add_result(it.idx, 0, s_vx[it.idx], s_vy[it.idx], s_vz[it.idx], 0, 1);
        REQ_READ_MIS: add_result(it.idx, 0, 0, 0, 0, m_flag[it.idx], 1);
        default: ;
      endcase
    endfunction

    function void check_beat(result_t got);
      result_t exp_r;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat idx=%0d", got.idx);
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.idx !== exp_r.idx || got.surv !== exp_r.surv || got.vx !== exp_r.vx ||
          got.vy !== exp_r.vy || got.vz !== exp_r.vz || got.flag !== exp_r.flag ||
          got.last !== exp_r.last) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch exp idx=%0d sv=%0b v=%h %h %h fl=%0b last=%0b",
                    " | got idx=%0d sv=%0b v=%h %h %h fl=%0b last=%0b"},
                   exp_r.idx, exp_r.surv, exp_r.vx, exp_r.vy, exp_r.vz, exp_r.flag,
                   exp_r.last, got.idx, got.surv, got.vx, got.vy, got.vz, got.flag,
                   got.last);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [REQ_W-1:0] in_req_type;
  logic [IDX_W-1:0] in_index;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y, in_vel_z;
  logic [31:0] in_radius, in_mass;
  logic in_active;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] out_object_index;
  logic out_survivor_valid;
  logic signed [31:0] out_vel_x, out_vel_y, out_vel_z;
  logic out_missile_active, out_last;
  logic cfg_valid, cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [CNT_W-1:0] cfg_data;

  collision_scoreboard sb = new();
  bit loaded[16];
  int hold_cnt = 0;

  localparam int SETTLE_CYCLES = 15000;

  sphere_collision_elastic_engine i_dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // accepted beats on both channels, sampled at the edge
  always @(posedge clk) begin
    request_t it;
    result_t  r;
    if (rst_n && in_valid && in_ready) begin
      it.req = in_req_type; it.idx = in_index;
      it.px = in_pos_x; it.py = in_pos_y; it.pz = in_pos_z;
      it.vx = in_vel_x; it.vy = in_vel_y; it.vz = in_vel_z;
      it.radius = in_radius; it.mass = in_mass; it.active = in_active;
      sb.note_request(it);
    end
    if (rst_n && out_valid && out_ready) begin
      r.idx = out_object_index; r.surv = out_survivor_valid;
      r.vx = out_vel_x; r.vy = out_vel_y; r.vz = out_vel_z;
      r.flag = out_missile_active; r.last = out_last;
      sb.check_beat(r);
    end
  end

  // receiver backpressure: mostly ready, short stalls, rare long ones
  always @(posedge clk) begin
    int p;
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else begin
      p = $urandom_range(0, 99);
      if (p < 65) begin
        out_ready <= 1'b1;
        hold_cnt  <= $urandom_range(0, 12);
      end else if (p < 95) begin
        out_ready <= 1'b0;
        hold_cnt  <= $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b0;
        hold_cnt  <= $urandom_range(20, 60);
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  task automatic send_request(request_t it);
    int gap;
    in_valid <= 1;
    in_req_type <= it.req; in_index <= it.idx;
    in_pos_x <= it.px; in_pos_y <= it.py; in_pos_z <= it.pz;
    in_vel_x <= it.vx; in_vel_y <= it.vy; in_vel_z <= it.vz;
    in_radius <= it.radius; in_mass <= it.mass; in_active <= it.active;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (it.req == REQ_LOAD_SPH) loaded[it.idx] = 1;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_count(logic [CFG_IW-1:0] which, logic [CNT_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= which;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    sb.set_count(which, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    // a collide pass leaves no pending results, so wait SETTLE_CYCLES for it
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic request_t blank(logic [REQ_W-1:0] req, int idx);
    request_t it;
    it.req = req; it.idx = IDX_W'(idx);
    it.px = $urandom; it.py = $urandom; it.pz = $urandom;
    it.vx = $urandom; it.vy = $urandom; it.vz = $urandom;
    it.radius = $urandom; it.mass = $urandom; it.active = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic logic [31:0] near_pos();
    return $urandom_range(0, 6 << 16) - (3 << 16);
  endfunction

  function automatic request_t rand_sphere(int idx);
    request_t it;
    it = blank(REQ_LOAD_SPH, idx);
    if ($urandom_range(0, 99) < 85) begin
      it.px = near_pos(); it.py = near_pos(); it.pz = near_pos();
      it.radius = $urandom_range(1 << 15, 2 << 16);
      case ($urandom_range(0, 3))
        0: it.mass = 1 << 16;
        1: it.mass = 2 << 16;
        2: it.mass = 3 << 16;
        default: it.mass = $urandom_range(0, 1 << 20);
      endcase
      if ($urandom_range(0, 4) != 0) begin
        it.vx = $urandom_range(0, 1 << 22) - (1 << 21);
        it.vy = $urandom_range(0, 1 << 22) - (1 << 21);
        it.vz = $urandom_range(0, 1 << 22) - (1 << 21);
      end
    end
    return it;
  endfunction

  function automatic request_t rand_missile(int idx);
    request_t it;
    it = blank(REQ_LOAD_MIS, idx);
    if ($urandom_range(0, 99) < 85) begin
      it.px = near_pos(); it.py = near_pos(); it.pz = near_pos();
      it.radius = $urandom_range(0, 1 << 16);
      it.active = $urandom_range(0, 9) < 7;
    end
    return it;
  endfunction

  function automatic request_t rand_request();
    int p, idx;
    p   = $urandom_range(0, 99);
    idx = $urandom_range(0, 15);
    if (p < 30) return rand_sphere(idx);
    if (p < 45) return rand_missile(idx);
    if (p < 58) return blank(REQ_COLLIDE, idx);
    if (p < 73) return blank(REQ_STRIKE, idx);
    if (p < 85) return blank(REQ_READ_SPH, loaded[idx] ? idx : 0);
    if (p < 97) return blank(REQ_READ_MIS, idx);
    return blank($urandom_range(0, 1) ? REQ_RSVD_A : REQ_RSVD_B, idx);
  endfunction

  task automatic run_phase(int objs, int mis, int n_items);
    int span;
    drain();
    write_count(CFG_OBJECT_COUNT, CNT_W'(objs));
    write_count(CFG_MISSILE_COUNT, CNT_W'(mis));
    span = objs > 16 ? 16 : objs;
    for (int i = 0; i < span; i++)
      if (!loaded[i]) send_request(rand_sphere(i));
    repeat (n_items) send_request(rand_request());
  endtask

  initial begin
    request_t it;
    int phase_objs[5] = '{16, 31, 2, 0, 5};
    int phase_mis[5]  = '{31, 16, 1, 0, 3};
    rst_n = 0;
    in_valid = 0; in_req_type = REQ_LOAD_SPH; in_index = 0;
    in_pos_x = 0; in_pos_y = 0; in_pos_z = 0; in_vel_x = 0; in_vel_y = 0; in_vel_z = 0;
    in_radius = 0; in_mass = 0; in_active = 0;
    cfg_valid = 0; cfg_index = CFG_OBJECT_COUNT; cfg_data = 0;
    foreach (loaded[k]) loaded[k] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // counts are zero: passes give nothing, flags read back zero
    send_request(blank(REQ_READ_MIS, 0));
    send_request(blank(REQ_STRIKE, 0));
    send_request(blank(REQ_COLLIDE, 0));
    send_request(blank(REQ_RSVD_A, 9));
    send_request(blank(REQ_RSVD_B, 10));

    it = blank(REQ_LOAD_SPH, 0);
    it.px = 0; it.py = 0; it.pz = 0;
    it.vx = 32'h7FFFFFFF; it.vy = 32'h80000000; it.vz = 32'hFFFFFFFF;
    it.radius = 1 << 16; it.mass = 1 << 16;
    send_request(it);
    it = blank(REQ_LOAD_SPH, 1);
    it.px = 1 << 16; it.py = 0; it.pz = 0;
    it.vx = 1; it.vy = 2; it.vz = 3;
    it.radius = 1 << 16; it.mass = 1 << 16;          // equal mass: velocity swap
    send_request(it);
    it = blank(REQ_LOAD_SPH, 2);
    it.px = 1 << 16; it.py = 1 << 15; it.pz = 0;
    it.vx = 32'h80000000; it.vy = 32'h7FFFFFFF; it.vz = -(5 << 16);
    it.radius = 1 << 16; it.mass = 3 << 16;          // unequal mass, saturating
    send_request(it);
    it = blank(REQ_LOAD_SPH, 3);
    it.px = 32'h7FFFFFFF; it.py = 32'h80000000; it.pz = 32'h7FFFFFFF;
    it.radius = 0; it.mass = 32'hFFFFFFFF;
    send_request(it);
    it = blank(REQ_LOAD_SPH, 15);
    it.px = 32'hFFFFFFFF; it.py = 32'hFFFFFFFF; it.pz = 32'hFFFFFFFF;
    it.vx = 0; it.vy = 0; it.vz = 0;
    it.radius = 32'hFFFFFFFF; it.mass = 0;
    send_request(it);
    it = blank(REQ_LOAD_MIS, 0);
    it.px = 0; it.py = 0; it.pz = 0; it.radius = 0; it.active = 1;
    send_request(it);
    it = blank(REQ_LOAD_MIS, 15);
    it.px = 32'h80000000; it.py = 32'h7FFFFFFF; it.pz = 32'h80000000;
    it.radius = 32'hFFFFFFFF; it.active = 0;
    send_request(it);
    send_request(blank(REQ_READ_SPH, 15));
    send_request(blank(REQ_READ_MIS, 0));
    send_request(blank(REQ_READ_MIS, 15));

    drain();
    write_count(CFG_OBJECT_COUNT, CNT_W'(4));
    write_count(CFG_MISSILE_COUNT, CNT_W'(16));
    send_request(blank(REQ_COLLIDE, 0));
    for (int i = 0; i < 4; i++) send_request(blank(REQ_READ_SPH, i));
    send_request(blank(REQ_STRIKE, 0));
    send_request(blank(REQ_READ_MIS, 0));

    for (int ph = 0; ph < 5; ph++) run_phase(phase_objs[ph], phase_mis[ph], 24);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
